// ===== sv/tdq_pkg.sv =====
// ============================================================================
// Touch d-pad quantizer package
// Shared types, register codes and constants for the touch d-pad quantizer.
// ============================================================================
package tdq_pkg;

    // Fixed field widths of the configuration registers.
    localparam int CENTER_BITS    = 12;
    localparam int RADIUS_BITS    = 12;
    localparam int DZ_BITS        = 8;
    localparam int PETALS         = 4;
    localparam int PETAL_IDX_BITS = 2;
    localparam int CFG_ADDR_BITS  = 5;
    localparam int CFG_DATA_BITS  = 32;

    // The dead zone is a fraction of 256, so the axis side of the compare
    // is scaled by 256 squared.
    localparam int SCALE_SHIFT    = 2 * DZ_BITS;

    // Register indexes (byte address divided by four).
    localparam logic [2:0] REG_CENTER_X   = 3'd0;
    localparam logic [2:0] REG_CENTER_Y   = 3'd1;
    localparam logic [2:0] REG_PAD_RADIUS = 3'd2;
    localparam logic [2:0] REG_DEAD_ZONE  = 3'd3;
    localparam logic [2:0] REG_BOUND_MASK = 3'd4;

    // Reset values of the registers.
    localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 12'd64;
    localparam logic [DZ_BITS-1:0]     DZ_RESET     = 8'd64;

    // Petal bit positions.
    localparam int PETAL_UP    = 0;
    localparam int PETAL_RIGHT = 1;
    localparam int PETAL_DOWN  = 2;
    localparam int PETAL_LEFT  = 3;

    typedef struct packed {
        logic [CENTER_BITS-1:0] center_x;
        logic [CENTER_BITS-1:0] center_y;
        logic [RADIUS_BITS-1:0] pad_radius;
        logic [DZ_BITS-1:0]     dead_zone;
        logic [PETALS-1:0]      bound_mask;
    } cfg_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CAPTURE,
        CMD_LOAD,
        CMD_SQ_X,
        CMD_SQ_Y,
        CMD_SQ_R,
        CMD_SQ_DZ,
        CMD_THR,
        CMD_DECIDE,
        CMD_EMIT
    } dp_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_R,
        ST_SQ_DZ,
        ST_THR,
        ST_DECIDE,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic release_item;
        logic pending_any;
        logic pending_one;
        logic out_free;
    } dp_status_t;

endpackage

// ===== sv/tdq_regs.sv =====
// ============================================================================
// Touch d-pad quantizer configuration registers
// APB-style register file holding the pad center, radius, dead zone and
// petal bindings.
// ============================================================================
module tdq_regs
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [tdq_pkg::CFG_ADDR_BITS-1:0]     paddr,
    input  logic [tdq_pkg::CFG_DATA_BITS-1:0]     pwdata,
    output logic [tdq_pkg::CFG_DATA_BITS-1:0]     prdata,
    output logic                                  pready,
    output tdq_pkg::cfg_t                         cfg
);

    tdq_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [2:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    // Register writes in the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x   <= '0;
            cfg_reg.center_y   <= '0;
            cfg_reg.pad_radius <= tdq_pkg::RADIUS_RESET;
            cfg_reg.dead_zone  <= tdq_pkg::DZ_RESET;
            cfg_reg.bound_mask <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                tdq_pkg::REG_CENTER_X:
                    cfg_reg.center_x <= pwdata[tdq_pkg::CENTER_BITS-1:0];
                tdq_pkg::REG_CENTER_Y:
                    cfg_reg.center_y <= pwdata[tdq_pkg::CENTER_BITS-1:0];
                tdq_pkg::REG_PAD_RADIUS:
                    cfg_reg.pad_radius <= pwdata[tdq_pkg::RADIUS_BITS-1:0];
                tdq_pkg::REG_DEAD_ZONE:
                    cfg_reg.dead_zone <= pwdata[tdq_pkg::DZ_BITS-1:0];
                tdq_pkg::REG_BOUND_MASK:
                    cfg_reg.bound_mask <= pwdata[tdq_pkg::PETALS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb
    begin
        unique case (reg_idx)
            tdq_pkg::REG_CENTER_X:
                prdata = tdq_pkg::CFG_DATA_BITS'(cfg_reg.center_x);
            tdq_pkg::REG_CENTER_Y:
                prdata = tdq_pkg::CFG_DATA_BITS'(cfg_reg.center_y);
            tdq_pkg::REG_PAD_RADIUS:
                prdata = tdq_pkg::CFG_DATA_BITS'(cfg_reg.pad_radius);
            tdq_pkg::REG_DEAD_ZONE:
                prdata = tdq_pkg::CFG_DATA_BITS'(cfg_reg.dead_zone);
            tdq_pkg::REG_BOUND_MASK:
                prdata = tdq_pkg::CFG_DATA_BITS'(cfg_reg.bound_mask);
            default:
                prdata = '0;
        endcase
    end

endmodule

// ===== sv/tdq_datapath.sv =====
// ============================================================================
// Touch d-pad quantizer datapath
// Offset, shared multiplier, threshold compare, petal state and the event
// output register.
// ============================================================================
module tdq_datapath
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  tdq_pkg::dp_cmd_t                       cmd,
    input  tdq_pkg::cfg_t                          cfg,
    input  logic                                   req_type,
    input  logic [COORD_BITS-1:0]                  touch_x,
    input  logic [COORD_BITS-1:0]                  touch_y,
    output tdq_pkg::dp_status_t                    status,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [tdq_pkg::PETAL_IDX_BITS-1:0]     petal_index,
    output logic                                   pressed,
    output logic                                   last_event
);

    // Offset width covers both the touch and the center coordinate.
    localparam int D       = (COORD_BITS > tdq_pkg::CENTER_BITS) ?
                             COORD_BITS : tdq_pkg::CENTER_BITS;
    localparam int SQ_BITS = 2 * D;
    localparam int S2_BITS = 2 * D + 1;
    localparam int DZ2_BITS = 2 * tdq_pkg::DZ_BITS;
    localparam int MA      = (D > DZ2_BITS) ? D : DZ2_BITS;
    localparam int MB      = S2_BITS;
    localparam int P_BITS  = MA + MB;

    // Captured item.
    logic                  req_reg;
    logic [COORD_BITS-1:0] tx_reg;
    logic [COORD_BITS-1:0] ty_reg;

    // Offsets as magnitude and sign.
    logic [D-1:0] adx_reg;
    logic [D-1:0] ady_reg;
    logic         dx_neg_reg;
    logic         dx_zero_reg;
    logic         dy_neg_reg;
    logic         dy_zero_reg;

    // Squares and threshold.
    logic [SQ_BITS-1:0]  sqx_reg;
    logic [SQ_BITS-1:0]  sqy_reg;
    logic [SQ_BITS-1:0]  rr_reg;
    logic [DZ2_BITS-1:0] dz2_reg;
    logic [S2_BITS-1:0]  s2_reg;
    logic [P_BITS-1:0]   thr_reg;

    // Petal tracking and pending events.
    logic [tdq_pkg::PETALS-1:0] petal_state_reg;
    logic [tdq_pkg::PETALS-1:0] pending_reg;
    logic [tdq_pkg::PETALS-1:0] press_reg;

    // Output register.
    logic                              out_valid_reg;
    logic [tdq_pkg::PETAL_IDX_BITS-1:0] petal_index_reg;
    logic                              pressed_reg;
    logic                              last_event_reg;

    logic [D:0]    dx_diff;
    logic [D:0]    dy_diff;
    logic [D:0]    dx_negated;
    logic [D:0]    dy_negated;
    logic [D-1:0]  adx_next;
    logic [D-1:0]  ady_next;
    logic [tdq_pkg::RADIUS_BITS-1:0] r_eff;
    logic [MA-1:0] mul_a;
    logic [MB-1:0] mul_b;
    logic [P_BITS-1:0] prod;
    logic [S2_BITS-1:0] sum_sq;
    logic [S2_BITS-1:0] s2_next;
    logic          hit_x;
    logic          hit_y;
    logic [tdq_pkg::PETALS-1:0] petal_next;
    logic [tdq_pkg::PETAL_IDX_BITS-1:0] sel_idx;
    logic          sel_found;
    logic [tdq_pkg::PETALS-1:0] pending_clr;
    logic          out_free;

    // Signed offsets from the pad center and their magnitudes.
    assign dx_diff    = {1'b0, D'(tx_reg)} - {1'b0, D'(cfg.center_x)};
    assign dy_diff    = {1'b0, D'(ty_reg)} - {1'b0, D'(cfg.center_y)};
    assign dx_negated = (D + 1)'(0) - dx_diff;
    assign dy_negated = (D + 1)'(0) - dy_diff;
    assign adx_next   = dx_diff[D] ? dx_negated[D-1:0] : dx_diff[D-1:0];
    assign ady_next   = dy_diff[D] ? dy_negated[D-1:0] : dy_diff[D-1:0];

    // A zero radius behaves as a radius of one.
    assign r_eff = (cfg.pad_radius == '0) ? tdq_pkg::RADIUS_BITS'(1) : cfg.pad_radius;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        unique case (cmd)
            tdq_pkg::CMD_SQ_X:
            begin
                mul_a = MA'(adx_reg);
                mul_b = MB'(adx_reg);
            end
            tdq_pkg::CMD_SQ_Y:
            begin
                mul_a = MA'(ady_reg);
                mul_b = MB'(ady_reg);
            end
            tdq_pkg::CMD_SQ_R:
            begin
                mul_a = MA'(r_eff);
                mul_b = MB'(r_eff);
            end
            tdq_pkg::CMD_SQ_DZ:
            begin
                mul_a = MA'(cfg.dead_zone);
                mul_b = MB'(cfg.dead_zone);
            end
            tdq_pkg::CMD_THR:
            begin
                mul_a = MA'(dz2_reg);
                mul_b = s2_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = P_BITS'(mul_a) * P_BITS'(mul_b);

    // Larger of the squared radius and the squared distance.
    assign sum_sq  = S2_BITS'(sqx_reg) + S2_BITS'(sqy_reg);
    assign s2_next = (sum_sq > S2_BITS'(rr_reg)) ? sum_sq : S2_BITS'(rr_reg);

    // Axis deflection against the dead-zone threshold.
    assign hit_x = (P_BITS'(sqx_reg) << tdq_pkg::SCALE_SHIFT) >= thr_reg;
    assign hit_y = (P_BITS'(sqy_reg) << tdq_pkg::SCALE_SHIFT) >= thr_reg;

    always_comb
    begin
        petal_next = '0;
        petal_next[tdq_pkg::PETAL_UP]    = (dy_neg_reg || dy_zero_reg) && hit_y;
        petal_next[tdq_pkg::PETAL_RIGHT] = !dx_neg_reg && hit_x;
        petal_next[tdq_pkg::PETAL_DOWN]  = !dy_neg_reg && hit_y;
        petal_next[tdq_pkg::PETAL_LEFT]  = (dx_neg_reg || dx_zero_reg) && hit_x;
    end

    // Lowest pending petal is emitted first.
    always_comb
    begin
        sel_idx   = '0;
        sel_found = 1'b0;
        for (int i = 0; i < tdq_pkg::PETALS; i++)
        begin
            if (pending_reg[i] && !sel_found)
            begin
                sel_idx   = tdq_pkg::PETAL_IDX_BITS'(i);
                sel_found = 1'b1;
            end
        end
    end

    assign pending_clr = pending_reg & ~(tdq_pkg::PETALS'(1) << sel_idx);
    assign out_free    = !out_valid_reg || !out_stall;

    assign status.release_item = req_reg;
    assign status.pending_any  = |pending_reg;
    assign status.pending_one  = (|pending_reg) && (pending_clr == '0);
    assign status.out_free     = out_free;

    // Payload registers of the arithmetic path.
    always_ff @(posedge clk)
    begin
        unique case (cmd)
            tdq_pkg::CMD_CAPTURE:
            begin
                req_reg <= req_type;
                tx_reg  <= touch_x;
                ty_reg  <= touch_y;
            end
            tdq_pkg::CMD_LOAD:
            begin
                adx_reg     <= adx_next;
                ady_reg     <= ady_next;
                dx_neg_reg  <= dx_diff[D];
                dy_neg_reg  <= dy_diff[D];
                dx_zero_reg <= (dx_diff == '0);
                dy_zero_reg <= (dy_diff == '0);
            end
            tdq_pkg::CMD_SQ_X:
                sqx_reg <= prod[SQ_BITS-1:0];
            tdq_pkg::CMD_SQ_Y:
                sqy_reg <= prod[SQ_BITS-1:0];
            tdq_pkg::CMD_SQ_R:
                rr_reg <= prod[SQ_BITS-1:0];
            tdq_pkg::CMD_SQ_DZ:
            begin
                dz2_reg <= prod[DZ2_BITS-1:0];
                s2_reg  <= s2_next;
            end
            tdq_pkg::CMD_THR:
                thr_reg <= prod;
            tdq_pkg::CMD_DECIDE:
                press_reg <= req_reg ? '0 : petal_next;
            default:
            begin
            end
        endcase
    end

    // Petal state and the pending event mask.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            petal_state_reg <= '0;
            pending_reg     <= '0;
        end
        else if (cmd == tdq_pkg::CMD_DECIDE)
        begin
            if (req_reg)
            begin
                petal_state_reg <= '0;
                pending_reg     <= cfg.bound_mask;
            end
            else
            begin
                petal_state_reg <= petal_next;
                pending_reg     <= (petal_next ^ petal_state_reg) & cfg.bound_mask;
            end
        end
        else if (cmd == tdq_pkg::CMD_EMIT && out_free)
        begin
            pending_reg <= pending_clr;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd == tdq_pkg::CMD_EMIT && out_free && sel_found)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (cmd == tdq_pkg::CMD_EMIT && out_free && sel_found)
        begin
            petal_index_reg <= sel_idx;
            pressed_reg     <= press_reg[sel_idx];
            last_event_reg  <= (pending_clr == '0);
        end
    end

    assign out_valid   = out_valid_reg;
    assign petal_index = petal_index_reg;
    assign pressed     = pressed_reg;
    assign last_event  = last_event_reg;

endmodule

// ===== sv/tdq_ctrl.sv =====
// ============================================================================
// Touch d-pad quantizer controller
// Sequences capture, squaring, threshold, decision and event emission.
// ============================================================================
module tdq_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  tdq_pkg::dp_status_t   status,
    output tdq_pkg::dp_cmd_t      cmd
);

    tdq_pkg::ctrl_state_t state_reg;
    tdq_pkg::ctrl_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tdq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Input is taken only between items.
    assign in_stall = (state_reg != tdq_pkg::ST_IDLE);

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = tdq_pkg::CMD_NONE;
        unique case (state_reg)
            tdq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = tdq_pkg::CMD_CAPTURE;
                    state_next = tdq_pkg::ST_LOAD;
                end
            end
            tdq_pkg::ST_LOAD:
            begin
                cmd        = tdq_pkg::CMD_LOAD;
                state_next = status.release_item ? tdq_pkg::ST_DECIDE : tdq_pkg::ST_SQ_X;
            end
            tdq_pkg::ST_SQ_X:
            begin
                cmd        = tdq_pkg::CMD_SQ_X;
                state_next = tdq_pkg::ST_SQ_Y;
            end
            tdq_pkg::ST_SQ_Y:
            begin
                cmd        = tdq_pkg::CMD_SQ_Y;
                state_next = tdq_pkg::ST_SQ_R;
            end
            tdq_pkg::ST_SQ_R:
            begin
                cmd        = tdq_pkg::CMD_SQ_R;
                state_next = tdq_pkg::ST_SQ_DZ;
            end
            tdq_pkg::ST_SQ_DZ:
            begin
                cmd        = tdq_pkg::CMD_SQ_DZ;
                state_next = tdq_pkg::ST_THR;
            end
            tdq_pkg::ST_THR:
            begin
                cmd        = tdq_pkg::CMD_THR;
                state_next = tdq_pkg::ST_DECIDE;
            end
            tdq_pkg::ST_DECIDE:
            begin
                cmd        = tdq_pkg::CMD_DECIDE;
                state_next = tdq_pkg::ST_EMIT;
            end
            tdq_pkg::ST_EMIT:
            begin
                if (!status.pending_any)
                begin
                    state_next = tdq_pkg::ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd = tdq_pkg::CMD_EMIT;
                    if (status.pending_one)
                    begin
                        state_next = tdq_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = tdq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/touch_dpad_direction_quantizer_unit.sv =====
// ============================================================================
// Touch d-pad direction quantizer
// Turns touch points into press and release events for four d-pad petals.
// ============================================================================
// Each touch or move item is measured against the configured pad center; the
// squared offset on each axis, scaled by 256 squared, is compared with the
// dead-zone fraction squared times the larger of radius squared and distance
// squared, and every bound petal whose state changes gives one event, in the
// order up, right, down, left, with last_event on the final one. A release
// item releases every bound petal. One item is worked at a time: a move item
// goes through capture, offset, four squarings and the threshold product on
// one shared multiplier, then the decision, and then gives its events one at
// a time whenever the output register is free; a release item goes from
// capture and offset straight to the decision. An item that gives no event
// still takes its full sequence. The next item is accepted while the last
// event still waits in the output register.
module touch_dpad_direction_quantizer_unit
#(
    // Width of the touch coordinates.
    parameter int COORD_BITS = 12
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [tdq_pkg::CFG_ADDR_BITS-1:0]     paddr,
    input  logic [tdq_pkg::CFG_DATA_BITS-1:0]     pwdata,
    output logic [tdq_pkg::CFG_DATA_BITS-1:0]     prdata,
    output logic                                  pready,

    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  req_type,
    input  logic [COORD_BITS-1:0]                 touch_x,
    input  logic [COORD_BITS-1:0]                 touch_y,

    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [tdq_pkg::PETAL_IDX_BITS-1:0]    petal_index,
    output logic                                  pressed,
    output logic                                  last_event
);

    tdq_pkg::cfg_t       cfg;
    tdq_pkg::dp_cmd_t    cmd;
    tdq_pkg::dp_status_t status;

    // Configuration registers.
    tdq_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer.
    tdq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Arithmetic, petal state and output register.
    tdq_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg         (cfg),
        .req_type    (req_type),
        .touch_x     (touch_x),
        .touch_y     (touch_y),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .petal_index (petal_index),
        .pressed     (pressed),
        .last_event  (last_event)
    );

endmodule

// ===== bench/touch_dpad_direction_quantizer_unit_test.sv =====
// ============================================================================
// Touch d-pad quantizer testbench
// Sends touch and release items through the quantizer under random idling
// on both sides. A built-in predictor works out the expected press and
// release events, and each event that comes out is checked field by field.
// ============================================================================
module touch_dpad_direction_quantizer_unit_test;

    import tdq_pkg::*;

    localparam int COORD_BITS = 12;

    // Item kinds on the req_type field.
    localparam logic REQ_MOVE    = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    typedef struct {
        logic                  rel;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } touch_req_t;

    typedef struct {
        logic [PETAL_IDX_BITS-1:0] petal_index;
        logic                      pressed;
        logic                      last_event;
    } dpad_evt_t;

    logic                      clk         = 1'b0;
    logic                      rst_n       = 1'b0;
    logic                      psel        = 1'b0;
    logic                      penable     = 1'b0;
    logic                      pwrite      = 1'b0;
    logic [CFG_ADDR_BITS-1:0]  paddr       = '0;
    logic [CFG_DATA_BITS-1:0]  pwdata      = '0;
    logic [CFG_DATA_BITS-1:0]  prdata;
    logic                      pready;
    logic                      in_valid    = 1'b0;
    logic                      in_stall;
    logic                      req_type    = REQ_MOVE;
    logic [COORD_BITS-1:0]     touch_x     = '0;
    logic [COORD_BITS-1:0]     touch_y     = '0;
    logic                      out_valid;
    logic                      out_stall   = 1'b0;
    logic [PETAL_IDX_BITS-1:0] petal_index;
    logic                      pressed;
    logic                      last_event;

    // Predictor state: a copy of the registers and of the petal state.
    cfg_t              shadow_cfg  = '{12'd0, 12'd0, RADIUS_RESET, DZ_RESET, 4'd0};
    logic [PETALS-1:0] petal_track = '0;

    touch_req_t touch_backlog[$];
    dpad_evt_t  awaited[$];
    int         mismatches = 0;

    // Idling state of the sender and the receiver.
    int         hold_off   = 0;
    int         stall_left = 0;
    int         draw;
    logic       in_calm    = 1'b0;
    logic       out_calm   = 1'b0;
    touch_req_t next_touch;
    dpad_evt_t  want;

    touch_dpad_direction_quantizer_unit #(.COORD_BITS(COORD_BITS)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .touch_x     (touch_x),
        .touch_y     (touch_y),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .petal_index (petal_index),
        .pressed     (pressed),
        .last_event  (last_event)
    );

    always #6 clk = ~clk;

    // Tells whether one axis offset reaches the dead-zone threshold on the
    // wanted side; a zero offset counts for both sides.
    function automatic logic petal_reached(input longint d, input logic want_pos,
                                           input longint unsigned limit);
        longint unsigned mag;
        if (want_pos && d < 0)
            return 1'b0;
        if (!want_pos && d > 0)
            return 1'b0;
        mag = (d < 0) ? -d : d;
        mag = mag * 256;
        return mag * mag >= limit;
    endfunction

    // Works out the events of one accepted item and updates the petal state.
    function automatic void quantize_touch(input logic rel, input logic [COORD_BITS-1:0] x,
                                           input logic [COORD_BITS-1:0] y);
        longint            dx;
        longint            dy;
        longint unsigned   rad;
        longint unsigned   span2;
        longint unsigned   dist2;
        longint unsigned   dz;
        longint unsigned   limit;
        logic [PETALS-1:0] next_petals;
        logic [PETALS-1:0] flips;
        dpad_evt_t         ev;
        dpad_evt_t         fresh[$];
        if (rel == REQ_RELEASE)
        begin
            // A release drops every petal and reports each bound one.
            next_petals = '0;
            flips = shadow_cfg.bound_mask;
        end
        else
        begin
            dx = longint'(x) - longint'(shadow_cfg.center_x);
            dy = longint'(y) - longint'(shadow_cfg.center_y);
            rad = (shadow_cfg.pad_radius == '0) ? 64'd1 : 64'(shadow_cfg.pad_radius);
            span2 = rad * rad;
            dist2 = dx * dx + dy * dy;
            if (dist2 > span2)
                span2 = dist2;
            dz = 64'(shadow_cfg.dead_zone);
            limit = dz * dz * span2;
            next_petals[PETAL_UP]    = petal_reached(dy, 1'b0, limit);
            next_petals[PETAL_RIGHT] = petal_reached(dx, 1'b1, limit);
            next_petals[PETAL_DOWN]  = petal_reached(dy, 1'b1, limit);
            next_petals[PETAL_LEFT]  = petal_reached(dx, 1'b0, limit);
            flips = (next_petals ^ petal_track) & shadow_cfg.bound_mask;
        end
        for (int p = 0; p < PETALS; p++)
        begin
            if (flips[p])
            begin
                ev.petal_index = PETAL_IDX_BITS'(p);
                ev.pressed     = next_petals[p];
                ev.last_event  = 1'b0;
                fresh.push_back(ev);
            end
        end
        if (fresh.size() != 0)
            fresh[fresh.size()-1].last_event = 1'b1;
        foreach (fresh[k])
            awaited.push_back(fresh[k]);
        petal_track = next_petals;
    endfunction

    // Driver: presents queued items, with a random hold-off after each one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            req_type <= REQ_MOVE;
            touch_x  <= '0;
            touch_y  <= '0;
            hold_off <= 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (hold_off != 0)
            begin
                in_valid <= 1'b0;
                hold_off <= hold_off - 1;
            end
            else if (touch_backlog.size() != 0)
            begin
                next_touch = touch_backlog.pop_front();
                in_valid <= 1'b1;
                req_type <= next_touch.rel;
                touch_x  <= next_touch.x;
                touch_y  <= next_touch.y;
                if ($urandom_range(0, 15) == 0)
                    in_calm <= !in_calm;
                hold_off <= in_calm ? 0 : int'($urandom_range(0, 4));
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: after each event, stalls for a random number of cycles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (out_valid && !out_stall)
        begin
            if ($urandom_range(0, 15) == 0)
                out_calm <= !out_calm;
            draw = out_calm ? 0 : int'($urandom_range(0, 4));
            stall_left <= draw;
            out_stall  <= (draw != 0);
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= (stall_left > 1);
        end
    end

    // Monitor: checks each event that leaves, then predicts each item that enters.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited.size() == 0)
                begin
                    $display("%0t: unexpected event, petal %0d pressed %0b last %0b",
                             $time, petal_index, pressed, last_event);
                    mismatches++;
                end
                else
                begin
                    want = awaited.pop_front();
                    if (petal_index !== want.petal_index)
                    begin
                        $display("%0t: petal_index expected %0d, actual %0d",
                                 $time, want.petal_index, petal_index);
                        mismatches++;
                    end
                    if (pressed !== want.pressed)
                    begin
                        $display("%0t: pressed expected %0b, actual %0b",
                                 $time, want.pressed, pressed);
                        mismatches++;
                    end
                    if (last_event !== want.last_event)
                    begin
                        $display("%0t: last_event expected %0b, actual %0b",
                                 $time, want.last_event, last_event);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
                quantize_touch(req_type, touch_x, touch_y);
        end
    end

    task automatic queue_item(input logic rel, input logic [COORD_BITS-1:0] x,
                              input logic [COORD_BITS-1:0] y);
        touch_req_t t;
        t.rel = rel;
        t.x   = x;
        t.y   = y;
        touch_backlog.push_back(t);
    endtask

    // One register write: setup cycle, then access cycle until pready.
    task automatic write_reg(input logic [2:0] idx, input logic [CFG_DATA_BITS-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CENTER_X:   shadow_cfg.center_x   = value[CENTER_BITS-1:0];
            REG_CENTER_Y:   shadow_cfg.center_y   = value[CENTER_BITS-1:0];
            REG_PAD_RADIUS: shadow_cfg.pad_radius = value[RADIUS_BITS-1:0];
            REG_DEAD_ZONE:  shadow_cfg.dead_zone  = value[DZ_BITS-1:0];
            REG_BOUND_MASK: shadow_cfg.bound_mask = value[PETALS-1:0];
            default: ;
        endcase
    endtask

    task automatic load_setup(input logic [11:0] cx, input logic [11:0] cy,
                              input logic [11:0] rad, input logic [7:0] dz,
                              input logic [3:0] mask);
        write_reg(REG_CENTER_X, CFG_DATA_BITS'(cx));
        write_reg(REG_CENTER_Y, CFG_DATA_BITS'(cy));
        write_reg(REG_PAD_RADIUS, CFG_DATA_BITS'(rad));
        write_reg(REG_DEAD_ZONE, CFG_DATA_BITS'(dz));
        write_reg(REG_BOUND_MASK, CFG_DATA_BITS'(mask));
        @(negedge clk);
    endtask

    // Waits until every item is taken and every event has arrived, then lets
    // the block finish any item that gives no event.
    task automatic drain();
        int waited;
        waited = 0;
        @(negedge clk);
        while (touch_backlog.size() != 0 || in_valid)
            @(negedge clk);
        while (awaited.size() != 0 && waited < 500)
        begin
            @(negedge clk);
            waited++;
        end
        if (awaited.size() != 0)
        begin
            $display("%0t: %0d expected events never arrived", $time, awaited.size());
            mismatches++;
            awaited.delete();
        end
        repeat (20)
            @(negedge clk);
    endtask

    // A coordinate within reach of a center, clipped to the screen.
    function automatic logic [COORD_BITS-1:0] near(input logic [COORD_BITS-1:0] c,
                                                   input int reach);
        int v;
        v = int'(c);
        v = v + int'($urandom_range(0, 2 * reach)) - reach;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v[COORD_BITS-1:0];
    endfunction

    // One random setting followed by touch gestures around its center.
    task automatic random_phase(input int count);
        logic [11:0] cx;
        logic [11:0] cy;
        logic [11:0] rad;
        logic [7:0]  dz;
        logic [3:0]  mask;
        int          made;
        int          reach;
        case ($urandom_range(0, 3))
            0:       cx = 12'd0;
            1:       cx = 12'd4095;
            default: cx = 12'($urandom_range(0, 4095));
        endcase
        case ($urandom_range(0, 3))
            0:       cy = 12'd0;
            1:       cy = 12'd4095;
            default: cy = 12'($urandom_range(0, 4095));
        endcase
        case ($urandom_range(0, 4))
            0:       rad = 12'd0;
            1:       rad = 12'd1;
            2:       rad = 12'd4095;
            default: rad = 12'($urandom_range(2, 600));
        endcase
        case ($urandom_range(0, 3))
            0:       dz = 8'd0;
            1:       dz = 8'd255;
            default: dz = 8'($urandom_range(1, 254));
        endcase
        mask = 4'($urandom_range(1, 15));
        load_setup(cx, cy, rad, dz, mask);
        made = 0;
        while (made < count)
        begin
            // A gesture: a few moves, usually closed by a release.
            repeat ($urandom_range(1, 6))
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    queue_item(REQ_MOVE, COORD_BITS'($urandom_range(0, 4095)),
                               COORD_BITS'($urandom_range(0, 4095)));
                end
                else
                begin
                    reach = $urandom_range(0, 1) ? 2 * int'(rad) + 4 : int'(rad) / 2 + 4;
                    queue_item(REQ_MOVE, near(cx, reach), near(cy, reach));
                end
                made++;
            end
            if ($urandom_range(0, 7) != 0)
            begin
                queue_item(REQ_RELEASE, COORD_BITS'($urandom_range(0, 4095)),
                           COORD_BITS'($urandom_range(0, 4095)));
                made++;
            end
        end
        drain();
    endtask

    initial
    begin
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: no petal is bound, so nothing may come out.
        queue_item(REQ_MOVE, 12'd0, 12'd0);
        queue_item(REQ_MOVE, 12'd4095, 12'd4095);
        queue_item(REQ_RELEASE, 12'd4095, 12'd0);
        drain();

        // Mid-screen pad, quarter dead zone: steps across each threshold.
        load_setup(12'd2048, 12'd2048, 12'd64, 8'd64, 4'hF);
        queue_item(REQ_MOVE, 12'd2048, 12'd2048);
        queue_item(REQ_MOVE, 12'd2064, 12'd2048);
        queue_item(REQ_MOVE, 12'd2063, 12'd2048);
        queue_item(REQ_MOVE, 12'd2048, 12'd2032);
        queue_item(REQ_MOVE, 12'd2048, 12'd2088);
        queue_item(REQ_MOVE, 12'd1984, 12'd2048);
        queue_item(REQ_MOVE, 12'd4095, 12'd4095);
        queue_item(REQ_MOVE, 12'd0, 12'd0);
        queue_item(REQ_MOVE, 12'd0, 12'd4095);
        queue_item(REQ_RELEASE, 12'd0, 12'd0);
        queue_item(REQ_RELEASE, 12'd4095, 12'd4095);
        drain();

        // Zero radius and zero dead zone: the center holds all four petals.
        load_setup(12'd100, 12'd3000, 12'd0, 8'd0, 4'hF);
        queue_item(REQ_MOVE, 12'd100, 12'd3000);
        queue_item(REQ_MOVE, 12'd105, 12'd3000);
        queue_item(REQ_MOVE, 12'd100, 12'd2990);
        queue_item(REQ_RELEASE, 12'd0, 12'd0);
        drain();

        // Far corner center, widest radius, full dead zone, half the petals
        // bound: unbound petals track silently, releases cover idle petals.
        load_setup(12'd4095, 12'd0, 12'd4095, 8'd255, 4'b0101);
        queue_item(REQ_MOVE, 12'd0, 12'd0);
        queue_item(REQ_MOVE, 12'd0, 12'd4095);
        queue_item(REQ_MOVE, 12'd4095, 12'd4095);
        queue_item(REQ_RELEASE, 12'd2048, 12'd2048);
        drain();

        repeat (5)
            random_phase(45);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Guard against a hung run.
    initial
    begin
        #4000000;
        $display("%0t: timeout", $time);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
